FILE: rtl/ndra_pkg.sv
package ndra_pkg;

  // Commands carried by an input item
  typedef enum logic [1:0] {
    CMD_TX_SUBMIT   = 2'd0,
    CMD_TX_COMPLETE = 2'd1,
    CMD_RX_DESC     = 2'd2,
    CMD_CNT_READ    = 2'd3
  } cmd_t;

  // Outcome codes reported with every result item
  typedef enum logic [2:0] {
    OUT_NONE    = 3'd0,
    OUT_QUEUED  = 3'd1,
    OUT_TX_OK   = 3'd2,
    OUT_TX_COLL = 3'd3,
    OUT_TX_ERR  = 3'd4,
    OUT_RX_OK   = 3'd5,
    OUT_RX_ERR  = 3'd6,
    OUT_RX_DROP = 3'd7
  } outcome_t;

  localparam int unsigned LEN_W      = 11;
  localparam int unsigned NUM_CNT    = 16;
  localparam int unsigned CNT_IDX_W  = 4;
  localparam int unsigned ENTRY_W    = 4;
  localparam int unsigned CVAL_W     = 32;

  // Statistics counter slots
  localparam int unsigned CNT_TX_PACKETS = 0;
  localparam int unsigned CNT_TX_ERRORS  = 1;
  localparam int unsigned CNT_TX_ABORTED = 2;
  localparam int unsigned CNT_TX_CARRIER = 3;
  localparam int unsigned CNT_TX_WINDOW  = 4;
  localparam int unsigned CNT_TX_FIFO    = 5;
  localparam int unsigned CNT_COLLISIONS = 6;
  localparam int unsigned CNT_RX_PACKETS = 7;
  localparam int unsigned CNT_RX_ERRORS  = 8;
  localparam int unsigned CNT_RX_FRAME   = 9;
  localparam int unsigned CNT_RX_OVER    = 10;
  localparam int unsigned CNT_RX_CRC     = 11;
  localparam int unsigned CNT_RX_FIFO    = 12;
  localparam int unsigned CNT_RX_DROPPED = 13;

  // Descriptor status byte
  localparam logic [7:0] ST_ERROR    = 8'h40;
  localparam logic [7:0] ST_COLL     = 8'h18;
  localparam logic [7:0] ST_RX_FRAME = 8'h20;
  localparam logic [7:0] ST_RX_OVER  = 8'h10;
  localparam logic [7:0] ST_RX_CRC   = 8'h08;
  localparam logic [7:0] ST_RX_FIFO  = 8'h04;

  // Transmit error word
  localparam logic [15:0] ERR_ABORT   = 16'h0400;
  localparam logic [15:0] ERR_CARRIER = 16'h0800;
  localparam logic [15:0] ERR_WINDOW  = 16'h1000;
  localparam logic [15:0] ERR_FIFO    = 16'h4000;

  // Configuration port
  localparam int unsigned   ADDR_W          = 3;
  localparam logic          REG_MIN_FRAME   = 1'b0;
  localparam logic [10:0]   MIN_FRAME_RESET = 11'd60;

  typedef struct packed {
    cmd_t        command;
    logic [10:0] frame_length;
    logic        host_owns;
    logic [7:0]  status_bits;
    logic [15:0] error_bits;
    logic        upper_accepts;
    logic [3:0]  counter_index;
  } req_item_t;

  typedef struct packed {
    logic [3:0]  entry_index;
    logic [10:0] send_length;
    logic        busy_res;
    outcome_t    outcome;
    logic        advanced;
    logic [31:0] counter_value;
  } rsp_item_t;

  // Transmit ring status toward the result stage
  typedef struct packed {
    logic [3:0]  entry;
    logic [10:0] send_length;
    outcome_t    outcome;
    logic        advanced;
    logic        busy;
  } tx_res_t;

endpackage

FILE: rtl/ndra_req_if.sv
interface ndra_req_if;
  import ndra_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ndra_rsp_if.sv
interface ndra_rsp_if;
  import ndra_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/nic_descriptor_ring_accounting_unit.sv
// Descriptor ring accounting for an ethernet controller.
// req carries one command item (transmit submit, transmit completion,
// receive descriptor, counter read); rsp returns exactly one result item
// for each, in order. Both are valid/ready channels.
// The APB port holds min_frame_length at address 0; writes are expected
// only while no item is in flight.
// An item accepted on req is held in the input register and moves on to
// the result register, which drives rsp.valid. Throughput: one item per
// cycle while rsp is not stalled; the ring indices, ownership bits and
// counters are all updated in the single logic stage between the two
// registers.
// When rsp stalls, the result register holds and the input register can
// still take one more item; req.ready drops only when both are full.
// Reset (rst, synchronous) empties both registers, clears the ring
// indices, ownership bits, busy flag and all counters, and sets
// min_frame_length to 60.
module nic_descriptor_ring_accounting_unit #(
  parameter int RING_ENTRIES  = 16,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  ndra_req_if.sink                   req,
  ndra_rsp_if.source                 rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ndra_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ndra_pkg::*;

  localparam int SW = $clog2(RING_ENTRIES);
  localparam logic [SW-1:0] LAST = SW'(RING_ENTRIES - 1);

  logic          in_valid;
  req_item_t     in_item;
  logic          fire;
  logic [10:0]   min_len;
  tx_res_t       tx_res;
  logic [15:0]   tx_bump;
  logic [15:0]   rx_bump;
  logic [31:0]   cnt_value;
  logic [SW-1:0] rx_slot;
  logic [SW-1:0] rx_slot_next;
  logic [SW+3:0] rx_entry_wide;
  logic          rx_adv;
  outcome_t      rx_outcome;
  rsp_item_t     result_next;

  // handshake: input stage moves on when the result register is free or being taken
  assign fire      = in_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.payload;
    end
  end

  ndra_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .min_len (min_len)
  );

  ndra_tx_ring #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_tx (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .command      (in_item.command),
    .frame_length (in_item.frame_length),
    .host_owns    (in_item.host_owns),
    .status_bits  (in_item.status_bits),
    .error_bits   (in_item.error_bits),
    .min_len      (min_len),
    .res          (tx_res),
    .bump         (tx_bump)
  );

  // receive side classification
  always_comb begin
    rx_bump    = '0;
    rx_outcome = OUT_NONE;
    rx_adv     = 1'b0;
    if ((in_item.command == CMD_RX_DESC) && in_item.host_owns) begin
      if ((in_item.status_bits & ST_ERROR) != '0) begin
        rx_outcome            = OUT_RX_ERR;
        rx_adv                = 1'b1;
        rx_bump[CNT_RX_ERRORS] = 1'b1;
        rx_bump[CNT_RX_FRAME]  = (in_item.status_bits & ST_RX_FRAME) != '0;
        rx_bump[CNT_RX_OVER]   = (in_item.status_bits & ST_RX_OVER) != '0;
        rx_bump[CNT_RX_CRC]    = (in_item.status_bits & ST_RX_CRC) != '0;
        rx_bump[CNT_RX_FIFO]   = (in_item.status_bits & ST_RX_FIFO) != '0;
      end else if (!in_item.upper_accepts) begin
        rx_outcome              = OUT_RX_DROP;
        rx_bump[CNT_RX_DROPPED] = 1'b1;
      end else begin
        rx_outcome              = OUT_RX_OK;
        rx_adv                  = 1'b1;
        rx_bump[CNT_RX_PACKETS] = 1'b1;
      end
    end
  end

  assign rx_slot_next  = (rx_slot == LAST) ? '0 : rx_slot + 1'b1;
  assign rx_entry_wide = {4'b0, rx_slot};

  // receive ring index
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_slot <= '0;
    end else if (fire && rx_adv) begin
      rx_slot <= rx_slot_next;
    end
  end

  ndra_stat_bank #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .bump     (tx_bump | rx_bump),
    .rd_index (in_item.counter_index),
    .rd_value (cnt_value)
  );

  // result assembly
  always_comb begin
    result_next.entry_index   = '0;
    result_next.send_length   = '0;
    result_next.busy_res      = tx_res.busy;
    result_next.outcome       = OUT_NONE;
    result_next.advanced      = 1'b0;
    result_next.counter_value = '0;
    unique case (in_item.command)
      CMD_TX_SUBMIT, CMD_TX_COMPLETE: begin
        result_next.entry_index = tx_res.entry;
        result_next.send_length = tx_res.send_length;
        result_next.outcome     = tx_res.outcome;
        result_next.advanced    = tx_res.advanced;
      end
      CMD_RX_DESC: begin
        result_next.entry_index = rx_entry_wide[3:0];
        result_next.outcome     = rx_outcome;
        result_next.advanced    = rx_adv;
      end
      CMD_CNT_READ: begin
        result_next.counter_value = cnt_value;
      end
      default: begin
        result_next.outcome = OUT_NONE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.payload <= result_next;
    end
  end

endmodule

FILE: rtl/ndra_cfg_regs.sv
module ndra_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ndra_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [10:0]                min_len
);
  import ndra_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && (reg_sel == REG_MIN_FRAME);

  // minimum frame length register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_FRAME_RESET;
    end else if (wr_en) begin
      min_len <= pwdata[10:0];
    end
  end

  // read back; unused addresses read zero
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_MIN_FRAME) begin
      prdata = {21'b0, min_len};
    end
  end

endmodule

FILE: rtl/ndra_tx_ring.sv
module ndra_tx_ring #(
  parameter int RING_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  ndra_pkg::cmd_t      command,
  input  logic [10:0]         frame_length,
  input  logic                host_owns,
  input  logic [7:0]          status_bits,
  input  logic [15:0]         error_bits,
  input  logic [10:0]         min_len,
  output ndra_pkg::tx_res_t   res,
  output logic [15:0]         bump
);
  import ndra_pkg::*;

  localparam int SW = $clog2(RING_ENTRIES);
  localparam logic [SW-1:0] LAST = SW'(RING_ENTRIES - 1);

  logic [SW-1:0]           next_slot;
  logic [SW-1:0]           oldest_slot;
  logic [RING_ENTRIES-1:0] owned;
  logic                    busy;

  logic [SW-1:0] next_slot_next;
  logic [SW-1:0] oldest_slot_next;
  logic          busy_next;
  logic          submit_ok;
  logic          retire;
  logic [SW+3:0] entry_wide;
  logic [SW-1:0] entry_slot;

  // submit takes a free slot, completion retires a returned one
  assign submit_ok = (command == CMD_TX_SUBMIT) && (frame_length != '0) && !owned[next_slot];
  assign retire    = (command == CMD_TX_COMPLETE) && (oldest_slot != next_slot) && host_owns;

  assign next_slot_next   = (next_slot == LAST) ? '0 : next_slot + 1'b1;
  assign oldest_slot_next = (oldest_slot == LAST) ? '0 : oldest_slot + 1'b1;

  // busy follows the owned bit of the next free slot after the update
  always_comb begin
    busy_next = busy;
    if (command == CMD_TX_SUBMIT) begin
      busy_next = submit_ok ? owned[next_slot_next] : owned[next_slot];
    end else if (command == CMD_TX_COMPLETE) begin
      busy_next = owned[next_slot];
    end
  end

  assign entry_slot = (command == CMD_TX_COMPLETE) ? oldest_slot : next_slot;
  assign entry_wide = {4'b0, entry_slot};

  // result and counter bumps
  always_comb begin
    res.entry       = entry_wide[3:0];
    res.send_length = '0;
    res.outcome     = OUT_NONE;
    res.advanced    = 1'b0;
    res.busy        = busy_next;
    bump            = '0;
    if (submit_ok) begin
      res.send_length = (frame_length < min_len) ? min_len : frame_length;
      res.outcome     = OUT_QUEUED;
      res.advanced    = 1'b1;
    end
    if (retire) begin
      res.advanced = 1'b1;
      if ((status_bits & ST_ERROR) != '0) begin
        res.outcome           = OUT_TX_ERR;
        bump[CNT_TX_ERRORS]   = 1'b1;
        bump[CNT_TX_ABORTED]  = (error_bits & ERR_ABORT) != '0;
        bump[CNT_TX_CARRIER]  = (error_bits & ERR_CARRIER) != '0;
        bump[CNT_TX_WINDOW]   = (error_bits & ERR_WINDOW) != '0;
        bump[CNT_TX_FIFO]     = (error_bits & ERR_FIFO) != '0;
      end else if ((status_bits & ST_COLL) != '0) begin
        res.outcome          = OUT_TX_COLL;
        bump[CNT_COLLISIONS] = 1'b1;
      end else begin
        res.outcome          = OUT_TX_OK;
        bump[CNT_TX_PACKETS] = 1'b1;
      end
    end
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot   <= '0;
      oldest_slot <= '0;
      owned       <= '0;
      busy        <= 1'b0;
    end else if (fire) begin
      busy <= busy_next;
      if (submit_ok) begin
        owned[next_slot] <= 1'b1;
        next_slot        <= next_slot_next;
      end
      if (retire) begin
        owned[oldest_slot] <= 1'b0;
        oldest_slot        <= oldest_slot_next;
      end
    end
  end

endmodule

FILE: rtl/ndra_stat_bank.sv
module ndra_stat_bank #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [ndra_pkg::NUM_CNT-1:0]   bump,
  input  logic [ndra_pkg::CNT_IDX_W-1:0] rd_index,
  output logic [31:0]                    rd_value
);
  import ndra_pkg::*;

  logic [COUNTER_WIDTH-1:0] cnt [NUM_CNT];
  logic [COUNTER_WIDTH+31:0] rd_wide;

  // wrapping event counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        cnt[k] <= '0;
      end
    end else if (fire) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        if (bump[k]) begin
          cnt[k] <= cnt[k] + 1'b1;
        end
      end
    end
  end

  assign rd_wide  = {32'b0, cnt[rd_index]};
  assign rd_value = rd_wide[31:0];

endmodule

FILE: test/tb_nic_descriptor_ring_accounting_unit.sv
module tb_nic_descriptor_ring_accounting_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ndra_pkg::*;

  localparam logic [ADDR_W-1:0] MIN_FRAME_ADDR = ADDR_W'(4 * REG_MIN_FRAME);
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 275;
  localparam int NUM_PHASES  = 6;

  // Ring and counter predictor plus the queue of results it expects
  class ring_ledger;
    logic [LEN_W-1:0]   min_len;
    logic [ENTRY_W-1:0] tx_next;
    logic [ENTRY_W-1:0] tx_oldest;
    logic [ENTRY_W-1:0] rx_next;
    logic               busy;
    bit                 owned[16];
    bit [CVAL_W-1:0]    stats[NUM_CNT];
    rsp_item_t          expected_results[$];
    int unsigned        failures;

    function new();
      min_len   = MIN_FRAME_RESET;
      tx_next   = '0;
      tx_oldest = '0;
      rx_next   = '0;
      busy      = 1'b0;
      failures  = 0;
      foreach (owned[i]) owned[i] = 1'b0;
      foreach (stats[i]) stats[i] = '0;
    endfunction

    function void bump(int unsigned k);
      stats[k] = stats[k] + 1'b1;
    endfunction

    // Work out the result of one accepted item and update the rings
    function void note_request(req_item_t r);
      rsp_item_t e;
      e = '0;
      case (r.command)
        CMD_TX_SUBMIT: begin
          e.entry_index = tx_next;
          if (r.frame_length != 0 && !owned[tx_next]) begin
            e.send_length = (r.frame_length < min_len) ? min_len : r.frame_length;
            owned[tx_next] = 1'b1;
            tx_next = tx_next + 1'b1;
            e.outcome = OUT_QUEUED;
            e.advanced = 1'b1;
          end
          busy = owned[tx_next];
        end
        CMD_TX_COMPLETE: begin
          e.entry_index = tx_oldest;
          if (tx_oldest != tx_next && r.host_owns) begin
            if ((r.status_bits & ST_ERROR) != 0) begin
              bump(CNT_TX_ERRORS);
              if ((r.error_bits & ERR_ABORT) != 0) bump(CNT_TX_ABORTED);
              if ((r.error_bits & ERR_CARRIER) != 0) bump(CNT_TX_CARRIER);
              if ((r.error_bits & ERR_WINDOW) != 0) bump(CNT_TX_WINDOW);
              if ((r.error_bits & ERR_FIFO) != 0) bump(CNT_TX_FIFO);
              e.outcome = OUT_TX_ERR;
            end else if ((r.status_bits & ST_COLL) != 0) begin
              bump(CNT_COLLISIONS);
              e.outcome = OUT_TX_COLL;
            end else begin
              bump(CNT_TX_PACKETS);
              e.outcome = OUT_TX_OK;
            end
            owned[tx_oldest] = 1'b0;
            tx_oldest = tx_oldest + 1'b1;
            e.advanced = 1'b1;
          end
          busy = owned[tx_next];
        end
        CMD_RX_DESC: begin
          e.entry_index = rx_next;
          if (r.host_owns) begin
            if ((r.status_bits & ST_ERROR) != 0) begin
              bump(CNT_RX_ERRORS);
              if ((r.status_bits & ST_RX_FRAME) != 0) bump(CNT_RX_FRAME);
              if ((r.status_bits & ST_RX_OVER) != 0) bump(CNT_RX_OVER);
              if ((r.status_bits & ST_RX_CRC) != 0) bump(CNT_RX_CRC);
              if ((r.status_bits & ST_RX_FIFO) != 0) bump(CNT_RX_FIFO);
              e.outcome = OUT_RX_ERR;
              rx_next = rx_next + 1'b1;
              e.advanced = 1'b1;
            end else if (!r.upper_accepts) begin
              // refused frame: counted, ring stays put
              bump(CNT_RX_DROPPED);
              e.outcome = OUT_RX_DROP;
            end else begin
              bump(CNT_RX_PACKETS);
              e.outcome = OUT_RX_OK;
              rx_next = rx_next + 1'b1;
              e.advanced = 1'b1;
            end
          end
        end
        default: begin
          e.counter_value = stats[r.counter_index];
        end
      endcase
      e.busy_res = busy;
      expected_results.push_back(e);
    endfunction

    // Compare one result item with the oldest expectation
    function void check_result(rsp_item_t got);
      rsp_item_t want;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: %p", got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.entry_index !== want.entry_index) begin
        $error("entry_index: expected %0d, actual %0d", want.entry_index, got.entry_index);
        failures++;
      end
      if (got.send_length !== want.send_length) begin
        $error("send_length: expected %0d, actual %0d", want.send_length, got.send_length);
        failures++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
        failures++;
      end
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
        failures++;
      end
      if (got.advanced !== want.advanced) begin
        $error("advanced: expected %0d, actual %0d", want.advanced, got.advanced);
        failures++;
      end
      if (got.counter_value !== want.counter_value) begin
        $error("counter_value: expected %0d, actual %0d", want.counter_value,
               got.counter_value);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ndra_req_if req_bus ();
  ndra_rsp_if rsp_bus ();

  ring_ledger ledger = new();
  bit         calm = 1'b0;
  int         quiet_cycles = 0;

  nic_descriptor_ring_accounting_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitor both channels; values read here are the ones before the edge
  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready) ledger.note_request(req_bus.payload);
    if (!rst && rsp_bus.valid && rsp_bus.ready) ledger.check_result(rsp_bus.payload);
    if (!rst && ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on cycles with no accepted item
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("nic_descriptor_ring_accounting_unit regression: fail");
    $finish;
  end

  // Result side: ready drops in random bursts until the calm phase
  initial begin : result_sink
    rsp_bus.ready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Offer one item, with an occasional idle burst ahead of it
  task automatic push_request(input req_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= it;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic send_fields(input cmd_t c, input logic [LEN_W-1:0] len, input logic host,
                             input logic [7:0] st, input logic [15:0] err, input logic acc,
                             input logic [CNT_IDX_W-1:0] idx);
    req_item_t it;
    it.command       = c;
    it.frame_length  = len;
    it.host_owns     = host;
    it.status_bits   = st;
    it.error_bits    = err;
    it.upper_accepts = acc;
    it.counter_index = idx;
    push_request(it);
  endtask

  // Stop offering items and let every expected result come back
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic read_min_frame(input logic [LEN_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MIN_FRAME_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LEN_W-1:0] !== want) begin
      $error("min_frame_length: expected %0d, actual %0d", want, prdata[LEN_W-1:0]);
      ledger.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_min_frame(input logic [LEN_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_FRAME_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.min_len = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    read_min_frame(v);
  endtask

  // Random item of a given command, lengths clustered near the padding edge
  function automatic req_item_t random_request(input cmd_t c);
    req_item_t r;
    r.command = c;
    case ($urandom_range(0, 9))
      0:       r.frame_length = '0;
      1:       r.frame_length = '1;
      2, 3:    r.frame_length = LEN_W'($urandom_range(0, 80));
      4:       r.frame_length = ledger.min_len + LEN_W'($urandom_range(0, 2)) - 1'b1;
      default: r.frame_length = LEN_W'($urandom_range(0, 2047));
    endcase
    r.host_owns = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 4))
      0:       r.status_bits = 8'($urandom_range(0, 255));
      1:       r.status_bits = ST_ERROR | 8'($urandom_range(0, 255));
      2:       r.status_bits = ST_COLL & 8'($urandom_range(1, 3) << 3);
      3:       r.status_bits = '0;
      default: r.status_bits = 8'($urandom_range(0, 255)) & ~ST_ERROR;
    endcase
    r.error_bits    = ($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom_range(0, 65535));
    r.upper_accepts = ($urandom_range(0, 4) != 0);
    r.counter_index = CNT_IDX_W'($urandom_range(0, 15));
    return r;
  endfunction

  initial begin : stimulus
    logic [LEN_W-1:0] phase_len[NUM_PHASES];
    int               mode;
    int               roll;
    cmd_t             c;

    req_bus.valid   <= 1'b0;
    req_bus.payload <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_min_frame(MIN_FRAME_RESET);

    // Directed: empty rings, zero and extreme lengths, every outcome
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_TX_COMPLETE, 0,    1, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_TX_SUBMIT,   0,    1, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_TX_SUBMIT,   1,    1, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_TX_SUBMIT,   2047, 1, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_TX_SUBMIT,   60,   1, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_TX_COMPLETE, 0,    0, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_TX_COMPLETE, 0,    1, ST_ERROR,  16'hffff, 1, 0);
    send_fields(CMD_TX_COMPLETE, 0,    1, ST_COLL,   ERR_ABORT, 1, 0);
    send_fields(CMD_TX_COMPLETE, 0,    1, 8'ha7,     16'h0000, 1, 0);
    send_fields(CMD_TX_COMPLETE, 0,    1, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_RX_DESC,     0,    0, 8'h00,     16'h0000, 1, 0);
    send_fields(CMD_RX_DESC,     0,    1, 8'hff,     16'h0000, 0, 0);
    send_fields(CMD_RX_DESC,     0,    1, 8'h00,     16'h0000, 0, 0);
    send_fields(CMD_RX_DESC,     0,    1, ST_COLL,   16'h0000, 1, 0);
    send_fields(CMD_RX_DESC,     0,    1, ST_ERROR,  16'h0000, 1, 0);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 1);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 2);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 6);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 7);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 8);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 9);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 13);
    send_fields(CMD_CNT_READ,    0,    1, 8'h00,     16'h0000, 1, 15);

    // Random phases, each under its own padding length
    phase_len[0] = '0;
    phase_len[1] = '1;
    phase_len[2] = 11'd1;
    phase_len[3] = MIN_FRAME_RESET;
    phase_len[4] = LEN_W'($urandom_range(0, 2047));
    phase_len[5] = 11'd1514;
    mode = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      program_min_frame(phase_len[p]);
      calm = (p == NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // windows that fill the transmit ring, drain it, or mix
        if (n % 40 == 0) mode = $urandom_range(0, 2);
        roll = $urandom_range(0, 99);
        case (mode)
          0:       c = (roll < 55) ? CMD_TX_SUBMIT : (roll < 70) ? CMD_TX_COMPLETE :
                       (roll < 90) ? CMD_RX_DESC : CMD_CNT_READ;
          1:       c = (roll < 10) ? CMD_TX_SUBMIT : (roll < 60) ? CMD_TX_COMPLETE :
                       (roll < 85) ? CMD_RX_DESC : CMD_CNT_READ;
          default: c = (roll < 30) ? CMD_TX_SUBMIT : (roll < 60) ? CMD_TX_COMPLETE :
                       (roll < 85) ? CMD_RX_DESC : CMD_CNT_READ;
        endcase
        push_request(random_request(c));
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (ledger.failures == 0) begin
      $display("nic_descriptor_ring_accounting_unit regression: pass");
    end else begin
      $display("nic_descriptor_ring_accounting_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ndra_pkg.sv
rtl/ndra_req_if.sv
rtl/ndra_rsp_if.sv
rtl/ndra_cfg_regs.sv
rtl/ndra_tx_ring.sv
rtl/ndra_stat_bank.sv
rtl/nic_descriptor_ring_accounting_unit.sv
test/tb_nic_descriptor_ring_accounting_unit.sv
